FILE: rtl/shcfb_pkg.sv
// ---------------------------------------------------------------------------
// shcfb_pkg: shared types and constants of the sync header CRC16 framer
// Byte roles, register indexes, emitter step codes and the byte-wide
// CRC-16/CCITT-FALSE update.
// ---------------------------------------------------------------------------
package shcfb_pkg;

  localparam int BYTE_W    = 8;
  localparam int ROLE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CRC_W     = 16;
  localparam int STEP_W    = 7;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_PAYLOAD = 2'd1,
    ROLE_CHECK   = 2'd2
  } role_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST     = 2'd0,
    REG_SYNC_SECOND    = 2'd1,
    REG_ID_STATE_FRAME = 2'd2,
    REG_ID_CALIB_FRAME = 2'd3
  } cfg_reg_t;

  typedef enum logic [STEP_W-1:0] {
    ST_SYNC1 = 7'b0000001,
    ST_SYNC2 = 7'b0000010,
    ST_ID    = 7'b0000100,
    ST_SEQ   = 7'b0001000,
    ST_PAY   = 7'b0010000,
    ST_CRCL  = 7'b0100000,
    ST_CRCH  = 7'b1000000
  } step_t;

  // MSB-first CRC update over one byte
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/shcfb_if.sv
// ---------------------------------------------------------------------------
// shcfb interfaces: input item, result and register write channels
// Each channel carries valid, ready and its payload fields.
// ---------------------------------------------------------------------------
interface shcfb_item_if;
  logic                          valid;
  logic                          ready;
  logic [shcfb_pkg::BYTE_W-1:0]  payload_byte;
  logic                          frame_start;
  logic                          frame_end;
  logic                          frame_kind;

  modport source (output valid, payload_byte, frame_start, frame_end, frame_kind,
                  input ready);
  modport sink   (input valid, payload_byte, frame_start, frame_end, frame_kind,
                  output ready);
endinterface

interface shcfb_result_if;
  logic                          valid;
  logic                          ready;
  logic [shcfb_pkg::BYTE_W-1:0]  out_byte;
  logic [shcfb_pkg::ROLE_W-1:0]  byte_role;
  logic                          run_last;
  logic                          frame_last;

  modport source (output valid, out_byte, byte_role, run_last, frame_last,
                  input ready);
  modport sink   (input valid, out_byte, byte_role, run_last, frame_last,
                  output ready);
endinterface

interface shcfb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [shcfb_pkg::CFG_IDX_W-1:0] index;
  logic [shcfb_pkg::BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sync_header_crc16_frame_builder.sv
// ---------------------------------------------------------------------------
// sync_header_crc16_frame_builder: byte framer with sync header and CRC16
// Wraps payload bytes into frames of sync, id, sequence, payload and a
// CRC-16/CCITT-FALSE trailer sent low byte first.
// ---------------------------------------------------------------------------
// A taken item goes to the emitter registers, then its results to the result register.
// Throughput: one result per cycle unless the output stalls; an item yields 0 to 7 results
//   and holds the emitter until its last is sent (payload-only bytes: one per cycle).
// The next item is taken in the cycle the emitter sends the current item's last byte.
// Reset: registers read 0, sequence 0, CRC FFFF, outside a frame, no result.
module sync_header_crc16_frame_builder (
  input  logic           clk,
  input  logic           rst,
  shcfb_cfg_if.sink      cfg,
  shcfb_item_if.sink     item,
  shcfb_result_if.source result
);
  import shcfb_pkg::*;

  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;
  logic [BYTE_W-1:0] id_state_frame;
  logic [BYTE_W-1:0] id_calib_frame;

  logic              inside_frame;
  logic [BYTE_W-1:0] frame_sequence;

  logic              busy;
  step_t             step;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_end;
  logic [BYTE_W-1:0] cur_id;
  logic [BYTE_W-1:0] cur_seq;
  logic [CRC_W-1:0]  crc;

  logic              res_valid;
  logic [BYTE_W-1:0] res_byte;
  logic [ROLE_W-1:0] res_role;
  logic              res_run_last;
  logic              res_frame_last;

  logic              item_fire;
  logic              take;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  role_t             emit_role;
  logic              step_last;
  logic              emit_frame_last;
  step_t             step_next;
  logic [CRC_W-1:0]  crc_base;
  logic [CRC_W-1:0]  crc_next;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first     <= '0;
      sync_second    <= '0;
      id_state_frame <= '0;
      id_calib_frame <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SYNC_FIRST:     sync_first     <= cfg.data;
        REG_SYNC_SECOND:    sync_second    <= cfg.data;
        REG_ID_STATE_FRAME: id_state_frame <= cfg.data;
        REG_ID_CALIB_FRAME: id_calib_frame <= cfg.data;
        default: ;
      endcase
    end
  end

  // accept side: frame tracking in item order
  assign item_fire = item.valid && item.ready;
  assign take      = item_fire && (item.frame_start || inside_frame);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame   <= 1'b0;
      frame_sequence <= '0;
    end else if (take) begin
      inside_frame <= !item.frame_end;
      if (item.frame_end) begin
        frame_sequence <= frame_sequence + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_byte <= item.payload_byte;
      cur_end  <= item.frame_end;
      cur_id   <= item.frame_kind ? id_calib_frame : id_state_frame;
      cur_seq  <= frame_sequence;
    end
  end

  // byte emitter
  assign emit = busy && (!res_valid || result.ready);

  always_comb begin
    emit_byte       = '0;
    emit_role       = ROLE_HEADER;
    step_last       = 1'b0;
    emit_frame_last = 1'b0;
    step_next       = ST_PAY;
    unique case (step)
      ST_SYNC1: begin
        emit_byte = sync_first;
        step_next = ST_SYNC2;
      end
      ST_SYNC2: begin
        emit_byte = sync_second;
        step_next = ST_ID;
      end
      ST_ID: begin
        emit_byte = cur_id;
        step_next = ST_SEQ;
      end
      ST_SEQ: begin
        emit_byte = cur_seq;
        step_next = ST_PAY;
      end
      ST_PAY: begin
        emit_byte = cur_byte;
        emit_role = ROLE_PAYLOAD;
        step_last = !cur_end;
        step_next = ST_CRCL;
      end
      ST_CRCL: begin
        emit_byte = crc[BYTE_W-1:0];
        emit_role = ROLE_CHECK;
        step_next = ST_CRCH;
      end
      ST_CRCH: begin
        emit_byte       = crc[CRC_W-1:BYTE_W];
        emit_role       = ROLE_CHECK;
        step_last       = 1'b1;
        emit_frame_last = 1'b1;
      end
      default: begin
        step_last = 1'b1;
      end
    endcase
  end

  // restart the CRC on the first sync byte of each frame
  assign crc_base   = (step == ST_SYNC1) ? CRC_INIT : crc;
  assign crc_next   = crc16_byte(crc_base, emit_byte);
  assign item.ready = !busy || (emit && step_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_PAY;
      crc  <= CRC_INIT;
    end else begin
      if (emit && (emit_role != ROLE_CHECK)) begin
        crc <= crc_next;
      end
      if (take) begin
        busy <= 1'b1;
        step <= item.frame_start ? ST_SYNC1 : ST_PAY;
      end else if (emit) begin
        if (step_last) begin
          busy <= 1'b0;
        end else begin
          step <= step_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_byte       <= emit_byte;
      res_role       <= emit_role;
      res_run_last   <= step_last;
      res_frame_last <= emit_frame_last;
    end
  end

  assign result.valid      = res_valid;
  assign result.out_byte   = res_byte;
  assign result.byte_role  = res_role;
  assign result.run_last   = res_run_last;
  assign result.frame_last = res_frame_last;

endmodule

FILE: rtl/shcfb_checker.sv
// ---------------------------------------------------------------------------
// shcfb_checker: port-level checks of the sync header CRC16 framer
// Watches the result stream for frame trailer ordering and output holding.
// ---------------------------------------------------------------------------
module shcfb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [shcfb_pkg::BYTE_W-1:0]   res_byte,
  input logic [shcfb_pkg::ROLE_W-1:0]   res_role,
  input logic                           res_run_last,
  input logic                           res_frame_last
);
  import shcfb_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_role)
      && $stable(res_run_last) && $stable(res_frame_last))
    else $error("stalled result changed");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_frame_last |-> res_run_last && (res_role == ROLE_CHECK))
    else $error("frame end not on a final checksum byte");

  // low CRC byte is followed at once by the high one
  a_crc_pair: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && (res_role == ROLE_CHECK) && !res_frame_last
      |=> res_valid && (res_role == ROLE_CHECK) && res_frame_last)
    else $error("high CRC byte missing");

  // a payload byte that does not close its item ends the frame
  a_pay_then_crc: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && (res_role == ROLE_PAYLOAD) && !res_run_last
      |=> res_valid && (res_role == ROLE_CHECK) && !res_frame_last)
    else $error("checksum does not follow last payload byte");

endmodule

bind sync_header_crc16_frame_builder shcfb_checker u_shcfb_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_byte       (result.out_byte),
  .res_role       (result.byte_role),
  .res_run_last   (result.run_last),
  .res_frame_last (result.frame_last)
);

FILE: sim/tb_sync_header_crc16_frame_builder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sync_header_crc16_frame_builder: self-checking bench for the CRC16 framer
// Streams marked payload bytes through the block under bursty input and a
// stalling output, predicts every framed byte (header, payload, CRC trailer)
// and compares each result in order, across several register settings.
// ---------------------------------------------------------------------------
module tb_sync_header_crc16_frame_builder;
  import shcfb_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;
  localparam int RAND_ITEMS   = 280;
  localparam int CHUNK_ITEMS  = 95;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_start;
    logic       frame_end;
    logic       frame_kind;
  } pay_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    role_t      byte_role;
    logic       run_last;
    logic       frame_last;
  } framed_byte_t;

  typedef enum logic [1:0] {
    RX_OPEN     = 2'd0,
    RX_SPARSE   = 2'd1,
    RX_PERIODIC = 2'd2,
    RX_COIN     = 2'd3
  } rx_mode_t;

  logic clk;
  logic rst;

  shcfb_cfg_if    cfg_ch ();
  shcfb_item_if   item_ch ();
  shcfb_result_if res_ch ();

  sync_header_crc16_frame_builder i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  // predictor state
  logic [7:0]   frame_regs [4];
  logic [15:0]  frame_crc;
  logic [7:0]   frame_seq;
  logic         in_frame;

  pay_item_t    pending_items [$];
  framed_byte_t framed_bytes_due [$];
  pay_item_t    drv_item;

  int items_queued = 0;
  int items_taken  = 0;
  int rand_queued  = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  int burst_left;
  int gap_left;

  int       hold_left;
  logic     hold_done;
  rx_mode_t rx_mode;
  int       mode_left;
  logic [1:0] tick;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      if (acc[15] ^ b[i]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  task automatic predict_framed_bytes(input pay_item_t it);
    logic [7:0]   frame_bytes [$];
    role_t        roles [$];
    framed_byte_t fb;
    if (it.frame_start) begin
      // a start always reopens: any unfinished frame is abandoned
      frame_crc = CRC_INIT;
      in_frame  = 1'b1;
      frame_bytes.push_back(frame_regs[REG_SYNC_FIRST]);
      frame_bytes.push_back(frame_regs[REG_SYNC_SECOND]);
      frame_bytes.push_back(it.frame_kind ? frame_regs[REG_ID_CALIB_FRAME]
                                          : frame_regs[REG_ID_STATE_FRAME]);
      frame_bytes.push_back(frame_seq);
      repeat (4) roles.push_back(ROLE_HEADER);
    end else if (!in_frame) begin
      return;
    end
    frame_bytes.push_back(it.payload_byte);
    roles.push_back(ROLE_PAYLOAD);
    foreach (frame_bytes[i]) frame_crc = crc_ccitt_next(frame_crc, frame_bytes[i]);
    if (it.frame_end) begin
      frame_bytes.push_back(frame_crc[7:0]);
      frame_bytes.push_back(frame_crc[15:8]);
      roles.push_back(ROLE_CHECK);
      roles.push_back(ROLE_CHECK);
      frame_seq++;
      in_frame  = 1'b0;
      frame_crc = CRC_INIT;
    end
    foreach (frame_bytes[i]) begin
      fb.out_byte   = frame_bytes[i];
      fb.byte_role  = roles[i];
      fb.run_last   = (i == frame_bytes.size() - 1);
      fb.frame_last = it.frame_end && (i == frame_bytes.size() - 1);
      framed_bytes_due.push_back(fb);
    end
  endtask

  task automatic note_mismatch(input string what, input framed_byte_t want,
                               input framed_byte_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte %02h role %0d run_last %b frame_last %b,",
               $realtime, what, want.out_byte, want.byte_role, want.run_last,
               want.frame_last);
      $display("    got byte %02h role %0d run_last %b frame_last %b",
               got.out_byte, got.byte_role, got.run_last, got.frame_last);
    end
  endtask

  task automatic queue_item(input logic [7:0] pb, input logic st, input logic en,
                            input logic kd);
    pay_item_t it;
    it.payload_byte = pb;
    it.frame_start  = st;
    it.frame_end    = en;
    it.frame_kind   = kd;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // mostly well-formed frames, many of them one byte long
  task automatic queue_random_items(input int n);
    int   made;
    int   len;
    int   pick;
    logic kind;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        // pick below 12 leaves the frame open for a later start to abandon
        len  = ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(2, 12);
        kind = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
          queue_item(8'($urandom_range(0, 255)), i == 0, (i == len - 1) && (pick >= 12),
                     (i == 0) ? kind : 1'($urandom_range(0, 1)));
        end
        made += len;
      end
    end
    rand_queued += made;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    frame_regs[idx] = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] ids, input logic [7:0] idc);
    write_reg(REG_SYNC_FIRST, s1);
    write_reg(REG_SYNC_SECOND, s2);
    write_reg(REG_ID_STATE_FRAME, ids);
    write_reg(REG_ID_CALIB_FRAME, idc);
  endtask

  // wait until every item is taken and every framed byte has come out
  task automatic wait_idle();
    while (items_taken != items_queued || framed_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // item driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (gap_left != 0) begin
        item_ch.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        item_ch.valid        <= 1'b1;
        item_ch.payload_byte <= drv_item.payload_byte;
        item_ch.frame_start  <= drv_item.frame_start;
        item_ch.frame_end    <= drv_item.frame_end;
        item_ch.frame_kind   <= drv_item.frame_kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // item monitor: feed the predictor with every accepted item
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) begin
      predict_framed_bytes({item_ch.payload_byte, item_ch.frame_start, item_ch.frame_end,
                            item_ch.frame_kind});
      items_taken++;
    end
  end

  // result receiver: changing stall modes, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
      rx_mode      <= RX_OPEN;
      mode_left    <= 0;
      tick         <= 2'd0;
    end else begin
      tick <= tick + 2'd1;
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        res_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   <= rx_mode_t'(2'($urandom_range(0, 3)));
          mode_left <= $urandom_range(20, 120);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          RX_OPEN:     res_ch.ready <= 1'b1;
          RX_SPARSE:   res_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: res_ch.ready <= (tick != 2'd0);
          default:     res_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // result monitor: compare against the oldest expected byte
  always @(posedge clk) begin
    framed_byte_t got;
    framed_byte_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen <= results_seen + 1;
      got.out_byte   = res_ch.out_byte;
      got.byte_role  = role_t'(res_ch.byte_role);
      got.run_last   = res_ch.run_last;
      got.frame_last = res_ch.frame_last;
      if (framed_bytes_due.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = framed_bytes_due.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_role !== want.byte_role ||
            got.run_last !== want.run_last || got.frame_last !== want.frame_last) begin
          note_mismatch("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int phase;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.payload_byte = 8'h00;
    item_ch.frame_start  = 1'b0;
    item_ch.frame_end    = 1'b0;
    item_ch.frame_kind   = 1'b0;
    res_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_SYNC_FIRST;
    cfg_ch.data          = 8'h00;
    frame_regs           = '{default: 8'h00};
    frame_crc            = CRC_INIT;
    frame_seq            = 8'h00;
    in_frame             = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // registers still at their reset value
    queue_item(8'h5A, 1'b0, 1'b0, 1'b0);  // stray byte, dropped
    queue_item(8'hC3, 1'b0, 1'b1, 1'b1);  // end with no frame open, dropped
    queue_item(8'h00, 1'b1, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b1, 1'b1);
    wait_idle();

    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_item(8'h01, 1'b1, 1'b0, 1'b1);
    queue_item(8'h80, 1'b0, 1'b0, 1'b0);  // kind off the start byte is ignored
    queue_item(8'h7F, 1'b0, 1'b1, 1'b1);
    queue_item(8'h11, 1'b1, 1'b0, 1'b0);
    queue_item(8'h22, 1'b0, 1'b0, 1'b1);
    queue_item(8'h33, 1'b1, 1'b0, 1'b1);  // restart abandons the open frame
    queue_item(8'h44, 1'b0, 1'b1, 1'b0);
    queue_item(8'h10, 1'b1, 1'b0, 1'b0);
    queue_item(8'hEF, 1'b1, 1'b1, 1'b1);  // restart that is a one-byte frame
    queue_item(8'hA5, 1'b0, 1'b0, 1'b1);  // after the close, dropped
    wait_idle();

    phase = 0;
    while (rand_queued < RAND_ITEMS) begin
      case (phase % 3)
        1:       program_regs(8'h00, 8'h00, 8'h00, 8'h00);
        default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      queue_random_items(CHUNK_ITEMS);
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/shcfb_pkg.sv
rtl/shcfb_if.sv
rtl/sync_header_crc16_frame_builder.sv
rtl/shcfb_checker.sv
sim/tb_sync_header_crc16_frame_builder.sv
